/* rtl/ple_pkg.sv */
// ple_pkg: request, status and cell-operation codes and the control struct
// broadcast along the element chain of the positional list engine
// no dependencies
package ple_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_INS_BEFORE = 3'd1;
   localparam logic [2:0] REQ_INS_AFTER  = 3'd2;
   localparam logic [2:0] REQ_APPEND     = 3'd3;
   localparam logic [2:0] REQ_DELETE     = 3'd4;
   localparam logic [2:0] REQ_READ       = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   // per-cell operation codes
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic [1:0]         op;     // hold, insert or delete
      logic [7:0]         idx;    // 0-based target index
      logic signed [31:0] value;  // word loaded at idx on insert
   } cell_ctrl_type;

endpackage

/* rtl/positional_list_engine.sv */
// positional_list_engine: ordered list of signed words held in a chain of
// element cells, with request decode, length counter and result register
// depends on ple_pkg and ple_cell
//
// usage
//   req channel: one request item per handshake; req_tuser carries the
//   request kind, req_tdata the value word and the 1-based position
//   rsp channel: one result item per request, carrying status, the list
//   length after the request and the value read or removed
//   timing: the result shows on rsp_tvalid in the cycle after req is accepted
//   throughput: one item per cycle while rsp_tready is high; every cell picks
//   shift, load or hold from the broadcast operation and its own index, so
//   an insert or a delete moves every cell of the list together
//   the read and delete value comes from an and-or select across the cells
//   stalls: the result register holds while rsp_tready is low; a new
//   request is accepted in the same cycle the pending result is taken
//   reset: synchronous, clears the length to zero and empties the result
//   register; cell contents are not cleared and are only ever read below
//   the current length
//   position 0 means the first element; a position past the length, or any
//   positional request on an empty list, reports bad position, and an
//   insert into a full list reports full; the list is left unchanged
module positional_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[39:32]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], length[6:2], read_value[38:7], zero[39]
);

   localparam int CW = $clog2(CAPACITY + 1);

   // request fields
   logic [2:0]         req_type;
   logic signed [31:0] req_value;
   logic [7:0]         req_position;

   assign req_type     = req_tuser;
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[39:32];

   // state
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [4:0]         rsp_length_ff;
   logic signed [31:0] rsp_read_ff;

   logic signed [31:0] cell_q [CAPACITY];

   // decode
   ple_pkg::cell_ctrl_type ctrl;
   logic                   req_fire;
   logic [7:0]             pos_eff;
   logic [7:0]             rd_idx;
   logic                   pos_ok;
   logic                   full;
   logic [1:0]             status_c;
   logic                   take_read;
   logic signed [31:0]     sel_value;
   logic signed [31:0]     read_c;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign pos_eff = (req_position == 8'd0) ? 8'd1 : req_position;
   assign rd_idx  = pos_eff - 8'd1;
   assign pos_ok  = (pos_eff <= 8'(count_ff));
   assign full    = (count_ff >= CW'(CAPACITY));

   always_comb begin
      ctrl.op    = ple_pkg::OP_HOLD;
      ctrl.idx   = rd_idx;
      ctrl.value = req_value;
      status_c   = ple_pkg::ST_OK;
      take_read  = 1'b0;
      unique case (req_type) inside
         ple_pkg::REQ_PUSH_FRONT, ple_pkg::REQ_APPEND: begin
            if (full) begin
               status_c = ple_pkg::ST_FULL;
            end else begin
               ctrl.op  = ple_pkg::OP_INSERT;
               ctrl.idx = (req_type == ple_pkg::REQ_PUSH_FRONT) ? 8'd0 : 8'(count_ff);
            end
         end
         ple_pkg::REQ_INS_BEFORE, ple_pkg::REQ_INS_AFTER: begin
            // position is checked ahead of capacity
            if (!pos_ok) begin
               status_c = ple_pkg::ST_BADPOS;
            end else if (full) begin
               status_c = ple_pkg::ST_FULL;
            end else begin
               ctrl.op  = ple_pkg::OP_INSERT;
               ctrl.idx = (req_type == ple_pkg::REQ_INS_BEFORE) ? rd_idx : pos_eff;
            end
         end
         ple_pkg::REQ_DELETE: begin
            if (!pos_ok) begin
               status_c = ple_pkg::ST_BADPOS;
            end else begin
               ctrl.op   = ple_pkg::OP_DELETE;
               take_read = 1'b1;
            end
         end
         ple_pkg::REQ_READ: begin
            if (!pos_ok) begin
               status_c = ple_pkg::ST_BADPOS;
            end else begin
               take_read = 1'b1;
            end
         end
         default: begin
            // unused request codes
            status_c = ple_pkg::ST_BADPOS;
         end
      endcase
      // cells only move on an accepted item
      if (!req_fire) begin
         ctrl.op = ple_pkg::OP_HOLD;
      end
   end

   // and-or select of the addressed cell
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_idx == 8'(i)) begin
            sel_value = sel_value | cell_q[i];
         end
      end
   end

   assign read_c = take_read ? sel_value : 32'sd0;

   // length counter
   always_comb begin
      count_in = count_ff;
      if (ctrl.op == ple_pkg::OP_INSERT) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.op == ple_pkg::OP_DELETE) begin
         count_in = count_ff - CW'(1);
      end
   end

   // element chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
      logic signed [31:0] left_v;
      logic signed [31:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_mid_l
         assign left_v = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = cell_q[g];
      end else begin : g_mid_r
         assign right_v = cell_q[g+1];
      end
      ple_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_value (left_v),
         .right_value(right_v),
         .cell_value (cell_q[g])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status_c;
         rsp_length_ff <= 5'(count_in);
         rsp_read_ff   <= read_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_read_ff, rsp_length_ff, rsp_status_ff};

   // length never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   // an insert grows the list by exactly one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == ple_pkg::OP_INSERT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list by one");

   // full is only reported on a full list
   a_full_only_full: assert property (@(posedge clock) disable iff (reset)
      req_fire && status_c == ple_pkg::ST_FULL |-> count_ff == CW'(CAPACITY))
      else $error("full reported on a list with room");

   // failed requests leave the list alone and read back zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && status_c != ple_pkg::ST_OK |-> ctrl.op == ple_pkg::OP_HOLD
         && read_c == 32'sd0)
      else $error("failed request changed the list or returned data");

endmodule

/* rtl/ple_cell.sv */
// ple_cell: one element slot of the list chain; shifts from its left or
// right neighbor, loads a new word or holds, decided from its own index
// depends on ple_pkg
module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  ple_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]     left_value,
   input  logic signed [31:0]     right_value,
   output logic signed [31:0]     cell_value
);

   localparam logic [7:0] MyIdx = 8'(INDEX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         ple_pkg::OP_HOLD: begin
            value_in = value_ff;
         end
         ple_pkg::OP_INSERT: begin
            // open a gap: cells past the target take the left neighbor
            if (MyIdx > ctrl.idx) begin
               value_in = left_value;
            end else if (MyIdx == ctrl.idx) begin
               value_in = ctrl.value;
            end
         end
         ple_pkg::OP_DELETE: begin
            // close the gap from the right
            if (MyIdx >= ctrl.idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

/* sim/positional_list_engine_test.sv */
// positional_list_engine_test: self-checking bench for the positional list engine
// holds its own list predictor and result scoreboard, drives both stream channels
// depends on ple_pkg and positional_list_engine
module positional_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAPACITY  = 16;
   localparam int RESET_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
   localparam int IDLE_LIMIT     = 3000;  // cycles without any handshake
   localparam int PHASE_ITEMS    = 200;
   localparam int PHASE_COUNT    = 9;

   // request codes the block does not define, both answered as bad position
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   typedef enum {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_kind_type;

   typedef struct {
      logic [1:0]         status;
      logic [4:0]         length;
      logic signed [31:0] read_value;
   } list_result_type;

   // list predictor plus queue of results still owed by the block
   class list_scoreboard;
      logic signed [31:0] cells[$];
      list_result_type    owed[$];
      int                 errors;
      int                 requests;
      int                 ok_count;
      int                 badpos_count;
      int                 full_count;
      int                 deepest;

      // work out what one accepted request does to the list
      function void note_request(logic [2:0] kind, logic signed [31:0] value,
                                 logic [7:0] position);
         int              slot;
         bit              slot_ok;
         list_result_type res;
         slot    = (position == 8'd0) ? 1 : int'(position);
         slot_ok = slot <= cells.size();
         res.status     = ple_pkg::ST_OK;
         res.read_value = '0;
         case (kind) inside
            ple_pkg::REQ_PUSH_FRONT, ple_pkg::REQ_APPEND: begin
               if (cells.size() >= LIST_CAPACITY) res.status = ple_pkg::ST_FULL;
               else if (kind == ple_pkg::REQ_PUSH_FRONT) cells.push_front(value);
               else cells.push_back(value);
            end
            ple_pkg::REQ_INS_BEFORE, ple_pkg::REQ_INS_AFTER: begin
               if (!slot_ok) res.status = ple_pkg::ST_BADPOS;
               else if (cells.size() >= LIST_CAPACITY) res.status = ple_pkg::ST_FULL;
               else if (kind == ple_pkg::REQ_INS_BEFORE) cells.insert(slot - 1, value);
               else if (slot == cells.size()) cells.push_back(value);
               else cells.insert(slot, value);
            end
            ple_pkg::REQ_DELETE: begin
               if (!slot_ok) res.status = ple_pkg::ST_BADPOS;
               else begin
                  res.read_value = cells[slot - 1];
                  cells.delete(slot - 1);
               end
            end
            ple_pkg::REQ_READ: begin
               if (!slot_ok) res.status = ple_pkg::ST_BADPOS;
               else res.read_value = cells[slot - 1];
            end
            default: res.status = ple_pkg::ST_BADPOS;
         endcase
         res.length = 5'(cells.size());
         owed.push_back(res);
         requests++;
         if (res.status == ple_pkg::ST_OK) ok_count++;
         else if (res.status == ple_pkg::ST_BADPOS) badpos_count++;
         else full_count++;
         if (cells.size() > deepest) deepest = cells.size();
      endfunction

      // compare one accepted result with the oldest one owed
      function void check_result(logic [39:0] data);
         list_result_type want;
         if (owed.size() == 0) begin
            $error("result item arrived with none expected: %h", data);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (data[1:0] !== want.status) begin
            $error("status expected %0d got %0d", want.status, data[1:0]);
            errors++;
         end
         if (data[6:2] !== want.length) begin
            $error("length expected %0d got %0d", want.length, data[6:2]);
            errors++;
         end
         if (data[38:7] !== want.read_value) begin
            $error("read_value expected %0d got %0d", want.read_value,
                   $signed(data[38:7]));
            errors++;
         end
         if (data[39] !== 1'b0) begin
            $error("pad bit expected 0 got %b", data[39]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // value[31:0], position[39:32]
   logic [2:0]  req_tuser = '0;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // status[1:0], length[6:2], read_value[38:7], zero[39]

   list_scoreboard board = new();

   bit long_hold;   // asks the receiver for one long hold-off
   bit calm;        // no idling on either side while set
   int idle_cycles;

   positional_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one item and hold it until the block takes it
   task automatic send_item(input logic [2:0] kind, input logic signed [31:0] value,
                            input logic [7:0] position);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {position, value};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, let the monitor note the last item, then wait until
   // every owed result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   // one random request, skewed by the phase so the list fills and empties
   task automatic send_random(input mix_kind_type mix);
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic [7:0]         position;
      int                 roll;
      int                 grow_cut;
      int                 read_cut;
      int                 len;
      len      = board.cells.size();
      grow_cut = (mix == MIX_GROW) ? 60 : (mix == MIX_EVEN) ? 40 : 22;
      read_cut = grow_cut + 20;
      roll = $urandom_range(0, 99);
      if (roll >= 95) kind = 3'($urandom_range(0, 7));   // noise, spare codes too
      else if (roll < grow_cut) begin
         case ($urandom_range(0, 3))
            0:       kind = ple_pkg::REQ_PUSH_FRONT;
            1:       kind = ple_pkg::REQ_INS_BEFORE;
            2:       kind = ple_pkg::REQ_INS_AFTER;
            default: kind = ple_pkg::REQ_APPEND;
         endcase
      end
      else if (roll < read_cut) kind = ple_pkg::REQ_READ;
      else kind = ple_pkg::REQ_DELETE;
      // positions mostly near the live range, now and then anywhere
      if ($urandom_range(0, 99) < 85) position = 8'($urandom_range(0, len + 1));
      else position = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 39))
         0:       value = 32'sh7fff_ffff;
         1:       value = 32'sh8000_0000;
         2:       value = '0;
         3:       value = -32'sd1;
         default: value = $urandom();
      endcase
      send_item(kind, value, position);
   endtask

   // the corner cases by hand: empty list, position zero, end of list, full list
   task automatic directed_items();
      int fill;
      send_item(ple_pkg::REQ_READ, 32'sd11, 8'd0);
      send_item(ple_pkg::REQ_DELETE, 32'sd12, 8'd1);
      send_item(ple_pkg::REQ_INS_BEFORE, 32'sd13, 8'd0);
      send_item(ple_pkg::REQ_INS_AFTER, 32'sd14, 8'd0);
      send_item(REQ_SPARE_A, 32'sd15, 8'd1);
      send_item(ple_pkg::REQ_PUSH_FRONT, 32'sh7fff_ffff, 8'd200);
      send_item(ple_pkg::REQ_APPEND, 32'sh8000_0000, 8'd255);
      send_item(ple_pkg::REQ_INS_BEFORE, 32'sd0, 8'd0);
      send_item(ple_pkg::REQ_INS_AFTER, -32'sd1, 8'd3);
      send_item(ple_pkg::REQ_INS_AFTER, 32'sd16, 8'd5);
      send_item(ple_pkg::REQ_READ, 32'sd17, 8'd255);
      send_item(ple_pkg::REQ_READ, 32'sd18, 8'd0);
      send_item(REQ_SPARE_B, 32'sd20, 8'd1);
      send_item(ple_pkg::REQ_DELETE, 32'sd19, 8'd2);
      // three left, fill up to capacity
      for (fill = 3; fill < LIST_CAPACITY; fill++)
         send_item(ple_pkg::REQ_APPEND, $urandom(), 8'($urandom_range(0, 255)));
      send_item(ple_pkg::REQ_PUSH_FRONT, 32'sd21, 8'd1);
      send_item(ple_pkg::REQ_APPEND, 32'sd22, 8'd1);
      send_item(ple_pkg::REQ_INS_BEFORE, 32'sd23, 8'(LIST_CAPACITY));
      send_item(ple_pkg::REQ_INS_AFTER, 32'sd24, 8'(LIST_CAPACITY + 1));
      send_item(ple_pkg::REQ_READ, 32'sd25, 8'(LIST_CAPACITY));
      send_item(ple_pkg::REQ_DELETE, 32'sd26, 8'(LIST_CAPACITY));
      send_item(ple_pkg::REQ_DELETE, 32'sd27, 8'd0);
   endtask

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[31:0], req_tdata[39:32]);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side: random ready pattern, one long hold-off when asked
   initial begin
      int busy;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            busy = $urandom_range(1, 12);
            rsp_tready <= 1'b1;
            repeat (busy) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // request side: reset, directed corners, then random phases
   initial begin
      int phase;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // receiver stalls while the sender keeps offering
         if (phase == 2) long_hold = 1'b1;
         // sender waits for the block to empty its output
         if (phase == 4) drain();
         calm = (phase == 6);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_random(mix_kind_type'(phase % 3));
      end
      drain();
      // result shows in the cycle after acceptance, leave a little slack
      repeat (4) @(posedge clock);
      $display("covered %0d requests: %0d ok, %0d bad position, %0d full",
               board.requests, board.ok_count, board.badpos_count, board.full_count);
      $display("list length reached %0d of %0d, with stalls on both channels",
               board.deepest, LIST_CAPACITY);
      if (board.errors == 0 && board.owed.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* positional_list_engine.f */
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
sim/positional_list_engine_test.sv
